@@ hdl/sha_pkg.sv @@
// sha-256 stream hasher shared package
// round constants, initial hash values, padding and sizing constants
// no dependencies
package sha_pkg;

    localparam int unsigned WordW     = 32;
    localparam int unsigned BlockWords = 16;
    localparam int unsigned Rounds    = 64;
    localparam int unsigned LenW      = 61;
    localparam logic [7:0]  PadByte   = 8'h80;
    localparam logic [5:0]  LenPos    = 6'd56;

    typedef logic [WordW-1:0] word_t;

    // round constant table
    function automatic word_t round_k(input logic [5:0] idx);
        word_t k;
        unique case (idx)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    // initial hash values
    function automatic word_t init_h(input logic [2:0] idx);
        word_t h;
        unique case (idx)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; 3'd7: h = 32'h5be0cd19;
            default: h = 32'h0;
        endcase
        return h;
    endfunction

    function automatic word_t rotr(input word_t x, input int unsigned n);
        return (x >> n) | (x << (WordW - n));
    endfunction

endpackage

@@ hdl/sha_if.sv @@
// request channel interfaces for the sha-256 stream hasher
// message input channel and digest output channel; no dependencies
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] message_byte;
    logic       byte_present;
    logic       end_of_message;
    modport source (output valid, message_byte, byte_present, end_of_message, input ready);
    modport sink   (input valid, message_byte, byte_present, end_of_message, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

@@ hdl/sha256_stream_hasher_unit.sv @@
// sha-256 stream hasher top level
// one byte per input request, eight digest words per message; uses sha_pkg, sha_if
// bytes are accepted one per cycle while the block fills; a full block then has its
// schedule loaded from the block memory, runs 64 rounds and an update step, and
// takes no bytes until that is done; at the end of a message padding completes one or two
// blocks, then 8 digest words leave one per accepted cycle
// asynchronous active-low reset restores initial hash values and clears counts
module sha256_stream_hasher_unit (
    input  logic      clk,
    input  logic      rst_n,
    sha_in_if.sink    msg_in,
    sha_out_if.source digest_out
);

    localparam logic [2:0] StIdle  = 3'd0;
    localparam logic [2:0] StPad   = 3'd1;
    localparam logic [2:0] StLenHi = 3'd2;
    localparam logic [2:0] StLenLo = 3'd3;
    localparam logic [2:0] StLoad  = 3'd4;
    localparam logic [2:0] StRound = 3'd5;
    localparam logic [2:0] StUpd   = 3'd6;
    localparam logic [2:0] StOut   = 3'd7;

    logic [2:0]                  state_reg, state_next;
    logic [5:0]                  fill_reg, fill_next;
    logic [sha_pkg::LenW-1:0]    len_reg, len_next;
    logic                        pend_end_reg, pend_end_next;
    logic                        final_reg, final_next;
    logic                        pad_first_reg, pad_first_next;
    logic [6:0]                  cnt_reg, cnt_next;
    logic [23:0]                 acc_reg, acc_next;
    sha_pkg::word_t              hash_reg [8];
    sha_pkg::word_t              wv_reg [8];
    sha_pkg::word_t              sched_reg [16];
    sha_pkg::word_t              rdata_reg;
    sha_pkg::word_t              block_mem [16];

    // byte path shared by message bytes and padding
    logic                        put_en;
    logic [7:0]                  put_byte;
    logic                        mem_we;
    logic [3:0]                  mem_waddr;
    sha_pkg::word_t              mem_wdata;
    logic [63:0]                 bit_len;

    assign bit_len = {len_reg, 3'b000};
    assign msg_in.ready = (state_reg == StIdle);
    assign digest_out.valid = (state_reg == StOut);
    assign digest_out.digest_word = hash_reg[cnt_reg[2:0]];
    assign digest_out.word_index = cnt_reg[2:0];
    assign digest_out.last_word = (cnt_reg[2:0] == 3'd7);

    // control sequencing
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        len_next       = len_reg;
        pend_end_next  = pend_end_reg;
        final_next     = final_reg;
        pad_first_next = pad_first_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        put_en         = 1'b0;
        put_byte       = 8'h00;
        mem_we         = 1'b0;
        mem_waddr      = fill_reg[5:2];
        mem_wdata      = {acc_reg, put_byte};
        unique case (state_reg)
            StIdle:
            begin
                if (msg_in.valid)
                begin
                    pend_end_next = msg_in.end_of_message;
                    pad_first_next = 1'b1;
                    if (msg_in.byte_present)
                    begin
                        len_next = len_reg + 1'b1;
                        put_en = 1'b1;
                        put_byte = msg_in.message_byte;
                        if (fill_reg == 6'd63)
                            state_next = StLoad;
                        else if (msg_in.end_of_message)
                            state_next = StPad;
                    end
                    else if (msg_in.end_of_message)
                    begin
                        state_next = StPad;
                    end
                end
            end
            StPad:
            begin
                if (pad_first_reg || fill_reg != sha_pkg::LenPos)
                begin
                    put_en = 1'b1;
                    put_byte = pad_first_reg ? sha_pkg::PadByte : 8'h00;
                    pad_first_next = 1'b0;
                    if (fill_reg == 6'd63)
                        state_next = StLoad;
                end
                else
                begin
                    state_next = StLenHi;
                end
            end
            StLenHi:
            begin
                mem_we = 1'b1;
                mem_waddr = 4'd14;
                mem_wdata = bit_len[63:32];
                state_next = StLenLo;
            end
            StLenLo:
            begin
                mem_we = 1'b1;
                mem_waddr = 4'd15;
                mem_wdata = bit_len[31:0];
                final_next = 1'b1;
                state_next = StLoad;
            end
            StLoad:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 7'd16)
                begin
                    cnt_next = '0;
                    state_next = StRound;
                end
            end
            StRound:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 7'(sha_pkg::Rounds - 1))
                begin
                    cnt_next = '0;
                    state_next = StUpd;
                end
            end
            StUpd:
            begin
                if (final_reg)
                    state_next = StOut;
                else if (pend_end_reg)
                    state_next = StPad;
                else
                    state_next = StIdle;
            end
            StOut:
            begin
                if (digest_out.ready)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg[2:0] == 3'd7)
                    begin
                        cnt_next = '0;
                        final_next = 1'b0;
                        pend_end_next = 1'b0;
                        len_next = '0;
                        fill_next = '0;
                        state_next = StIdle;
                    end
                end
            end
            default: state_next = StIdle;
        endcase
        // byte packing into big-endian words
        if (put_en)
        begin
            acc_next = {acc_reg[15:0], put_byte};
            fill_next = fill_reg + 1'b1;
            mem_wdata = {acc_reg, put_byte};
            mem_waddr = fill_reg[5:2];
            mem_we = (fill_reg[1:0] == 2'd3);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= StIdle;
            fill_reg      <= '0;
            len_reg       <= '0;
            pend_end_reg  <= 1'b0;
            final_reg     <= 1'b0;
            pad_first_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            len_reg       <= len_next;
            pend_end_reg  <= pend_end_next;
            final_reg     <= final_next;
            pad_first_reg <= pad_first_next;
            cnt_reg       <= cnt_next;
        end
    end

    // block memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (mem_we)
            block_mem[mem_waddr] <= mem_wdata;
        rdata_reg <= block_mem[cnt_reg[3:0]];
    end

    // round datapath
    sha_pkg::word_t s0_w, s1_w, new_w, t1, t2, ch, maj, ep0, ep1;
    always_comb
    begin
        s0_w = sha_pkg::rotr(sched_reg[1], 7) ^ sha_pkg::rotr(sched_reg[1], 18)
             ^ (sched_reg[1] >> 3);
        s1_w = sha_pkg::rotr(sched_reg[14], 17) ^ sha_pkg::rotr(sched_reg[14], 19)
             ^ (sched_reg[14] >> 10);
        new_w = s1_w + sched_reg[9] + s0_w + sched_reg[0];
        ep1 = sha_pkg::rotr(wv_reg[4], 6) ^ sha_pkg::rotr(wv_reg[4], 11)
            ^ sha_pkg::rotr(wv_reg[4], 25);
        ep0 = sha_pkg::rotr(wv_reg[0], 2) ^ sha_pkg::rotr(wv_reg[0], 13)
            ^ sha_pkg::rotr(wv_reg[0], 22);
        ch = (wv_reg[4] & wv_reg[5]) ^ (~wv_reg[4] & wv_reg[6]);
        maj = (wv_reg[0] & wv_reg[1]) ^ (wv_reg[0] & wv_reg[2]) ^ (wv_reg[1] & wv_reg[2]);
        t1 = wv_reg[7] + ep1 + ch + sha_pkg::round_k(cnt_reg[5:0]) + sched_reg[0];
        t2 = ep0 + maj;
    end

    // schedule window, working variables and hash state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                hash_reg[i] <= sha_pkg::init_h(3'(i));
        end
        else if (state_reg == StUpd)
        begin
            for (int i = 0; i < 8; i++)
                hash_reg[i] <= hash_reg[i] + wv_reg[i];
        end
        else if (state_reg == StOut && digest_out.ready && cnt_reg[2:0] == 3'd7)
        begin
            for (int i = 0; i < 8; i++)
                hash_reg[i] <= sha_pkg::init_h(3'(i));
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == StLoad)
        begin
            for (int i = 0; i < 8; i++)
                wv_reg[i] <= hash_reg[i];
            if (cnt_reg != 7'd0)
            begin
                for (int i = 0; i < 15; i++)
                    sched_reg[i] <= sched_reg[i+1];
                sched_reg[15] <= rdata_reg;
            end
        end
        else if (state_reg == StRound)
        begin
            for (int i = 0; i < 15; i++)
                sched_reg[i] <= sched_reg[i+1];
            sched_reg[15] <= new_w;
            wv_reg[7] <= wv_reg[6];
            wv_reg[6] <= wv_reg[5];
            wv_reg[5] <= wv_reg[4];
            wv_reg[4] <= wv_reg[3] + t1;
            wv_reg[3] <= wv_reg[2];
            wv_reg[2] <= wv_reg[1];
            wv_reg[1] <= wv_reg[0];
            wv_reg[0] <= t1 + t2;
        end
    end

endmodule

@@ hdl/sha256_stream_hasher_checker.sv @@
// port-level checker for the sha-256 stream hasher
// watches the input and digest channels; bound to sha256_stream_hasher_unit
module sha256_stream_hasher_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_word,
    input logic [2:0]  out_index,
    input logic        out_last
);

    // no message request taken while digest words are pending
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !in_ready)
        else $error("input ready while digest pending");

    // last flag marks index seven only
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_last == (out_index == 3'd7)))
        else $error("last flag mismatch");

    // words leave in index order
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !out_last) |=> (out_valid && out_index == $past(out_index) + 3'd1))
        else $error("digest word order broken");

    // stalled word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_word)))
        else $error("stalled digest word changed");

endmodule

bind sha256_stream_hasher_unit sha256_stream_hasher_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (msg_in.ready),
    .out_valid (digest_out.valid),
    .out_ready (digest_out.ready),
    .out_word  (digest_out.digest_word),
    .out_index (digest_out.word_index),
    .out_last  (digest_out.last_word)
);
